/* rtl/rda_pkg.sv */
// rda_pkg: shared types and constants of the ranging distance averager
// payload structs, divider request/response structs and the sequencer state type
// no dependencies
`default_nettype none

package rda_pkg;

  // field widths
  localparam int BYTE_W = 8;
  localparam int SUM_W  = 26;
  localparam int CNT_W  = 8;
  localparam int MM_W   = 18;
  localparam int CM_W   = 15;
  localparam int SLOT_W = 4;

  // serial divider operand widths
  localparam int DIV_W  = SUM_W;
  localparam int DVSR_W = CNT_W;

  // unit weights and reset value of the refresh register
  localparam logic [9:0]       MM_PER_M    = 10'd1000;
  localparam logic [3:0]       MM_PER_CM   = 4'd10;
  localparam logic [CNT_W-1:0] REFRESH_RST = 8'd5;
  localparam logic [CNT_W-1:0] CNT_MAX     = 8'd255;

  // one distance report
  typedef struct packed {
    logic [BYTE_W-1:0] anchor_number;
    logic [BYTE_W-1:0] whole_meters;
    logic [BYTE_W-1:0] centimeters;
  } rda_in_t;

  // one filtered result
  typedef struct packed {
    logic [SLOT_W-1:0] anchor_slot;
    logic [MM_W-1:0]   filtered_mm;
    logic [CM_W-1:0]   filtered_cm;
    logic              had_reports;
    logic              last_of_round;
  } rda_out_t;

  // divider control
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } rda_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } rda_div_rsp_t;

  // round sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CHECK,
    ST_SLOT,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_RING_RD,
    ST_RING_WR,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_CM_GO,
    ST_CM_WAIT,
    ST_LOAD
  } rda_state_t;

endpackage

`default_nettype wire

/* rtl/rda_serial_div.sv */
// rda_serial_div: bit-serial restoring divider, one quotient bit per cycle
// dividend DIV_W bits, divisor DVSR_W bits (never zero), done pulses when finished
// depends on rda_pkg
`default_nettype none

module rda_serial_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rda_pkg::rda_div_req_t req,
  output rda_pkg::rda_div_rsp_t rsp
);

  localparam int STEP_W = $clog2(rda_pkg::DIV_W + 1);

  logic [rda_pkg::DIV_W-1:0]  shift_r, shift_nxt;
  logic [rda_pkg::DVSR_W-1:0] rem_r, rem_nxt;
  logic [rda_pkg::DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       done_r, done_nxt;
  logic [rda_pkg::DVSR_W:0]   trial;
  logic                       fits;

  // one restoring step: dividend bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    trial     = {rem_r, shift_r[rda_pkg::DIV_W-1]};
    fits      = trial >= {1'b0, dvsr_r};
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    dvsr_nxt  = dvsr_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      shift_nxt = req.dividend;
      rem_nxt   = '0;
      dvsr_nxt  = req.divisor;
      step_nxt  = STEP_W'(rda_pkg::DIV_W);
    end else if (step_r != '0) begin
      shift_nxt = {shift_r[rda_pkg::DIV_W-2:0], fits};
      rem_nxt   = fits ? rda_pkg::DVSR_W'(trial - {1'b0, dvsr_r})
                       : trial[rda_pkg::DVSR_W-1:0];
      step_nxt  = step_r - 1'b1;
      done_nxt  = (step_r == STEP_W'(1));
    end
  end

  // step counter and done flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    dvsr_r  <= dvsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = shift_r;

endmodule

`default_nettype wire

/* rtl/ranging_distance_averager.sv */
// Ranging distance averager. Each report adds meters*1000 + centimeters*10 to its
// anchor's millimeter sum and bumps that anchor's count; reports for an anchor at or
// above ANCHORS are dropped. When any count reaches refresh_count a round runs: for
// every anchor in order the block mean sum/count is taken, a nonzero mean enters the
// anchor's ring of SMOOTH_DEPTH entries, and the ring average (and that divided by
// ten) goes out, one transaction per anchor, the last one flagged; then sums and
// counts clear. How long a round runs is set by the one shared bit-serial divider,
// which runs three 26-step divisions (block mean, ring average, centimeters) per
// anchor with reports, and is lengthened by any output stall. The ring memory
// needs no clearing pass: per-entry valid bits make unwritten entries read as zero.
// Depends on rda_pkg and rda_serial_div.
`default_nettype none

module ranging_distance_averager #(
  parameter int ANCHORS      = 4,
  parameter int SMOOTH_DEPTH = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // report channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  rda_pkg::rda_in_t        in_data,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output rda_pkg::rda_out_t       out_data,
  // refresh count register
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [rda_pkg::CNT_W-1:0] cfg_data
);

  localparam int AW     = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;
  localparam int PW     = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
  localparam int RING_N = ANCHORS * SMOOTH_DEPTH;
  localparam int RAW    = (RING_N > 1) ? $clog2(RING_N) : 1;
  localparam int AD_W   = RAW + 4;
  localparam int TOT_W  = rda_pkg::MM_W + PW;

  rda_pkg::rda_state_t state_r, state_nxt;

  logic [rda_pkg::CNT_W-1:0] refresh_r;
  logic [rda_pkg::SUM_W-1:0] sum_r   [ANCHORS];
  logic [rda_pkg::CNT_W-1:0] cnt_r   [ANCHORS];
  logic [PW-1:0]             pos_r   [ANCHORS];
  logic [TOT_W-1:0]          total_r [ANCHORS];

  logic [rda_pkg::MM_W-1:0]  ring_mem [RING_N];
  logic [RING_N-1:0]         ring_vld_r;

  logic [AW-1:0]             a_idx_r;
  logic [rda_pkg::MM_W-1:0]  addend_r;
  logic [rda_pkg::SUM_W-1:0] mean_r;
  logic [rda_pkg::MM_W-1:0]  ring_rd_r;
  logic                      old_vld_r;
  logic [rda_pkg::MM_W-1:0]  filt_r;
  logic [rda_pkg::CM_W-1:0]  cm_r;
  logic                      had_r;
  logic                      out_valid_r;
  rda_pkg::rda_out_t         out_data_r;

  rda_pkg::rda_div_req_t     div_req;
  rda_pkg::rda_div_rsp_t     div_rsp;

  logic                      in_ok;
  logic                      fire;
  logic [rda_pkg::MM_W-1:0]  addend;
  logic [rda_pkg::CNT_W-1:0] cur_cnt;
  logic [rda_pkg::SUM_W-1:0] cur_sum;
  logic [PW-1:0]             cur_pos;
  logic [PW-1:0]             next_pos;
  logic [TOT_W-1:0]          cur_tot;
  logic [AD_W-1:0]           addr_full;
  logic [RAW-1:0]            ring_addr;
  logic [rda_pkg::MM_W-1:0]  old_mm;
  logic [rda_pkg::MM_W-1:0]  mean_mm;
  logic                      mean_nz;
  logic                      last_slot;
  logic                      out_free;
  logic                      accept_c;
  logic                      ring_we_c;
  logic                      load_c;

  // shared bit-serial divider
  rda_serial_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // report decode and millimeter addend
  assign in_ok  = in_data.anchor_number < rda_pkg::BYTE_W'(ANCHORS);
  assign addend = rda_pkg::MM_W'(rda_pkg::MM_W'(in_data.whole_meters) *
                                 rda_pkg::MM_W'(rda_pkg::MM_PER_M))
                + rda_pkg::MM_W'(rda_pkg::MM_W'(in_data.centimeters) *
                                 rda_pkg::MM_W'(rda_pkg::MM_PER_CM));

  // round trigger: any anchor at or above the refresh count
  always_comb begin
    fire = 1'b0;
    for (int k = 0; k < ANCHORS; k++) begin
      if (cnt_r[k] >= refresh_r) begin
        fire = 1'b1;
      end
    end
  end

  // current anchor's state
  assign cur_cnt   = cnt_r[a_idx_r];
  assign cur_sum   = sum_r[a_idx_r];
  assign cur_pos   = pos_r[a_idx_r];
  assign cur_tot   = total_r[a_idx_r];
  assign next_pos  = (cur_pos == PW'(SMOOTH_DEPTH - 1)) ? '0 : cur_pos + 1'b1;
  assign addr_full = AD_W'(a_idx_r) * AD_W'(SMOOTH_DEPTH) + AD_W'(cur_pos);
  assign ring_addr = addr_full[RAW-1:0];
  assign old_mm    = old_vld_r ? ring_rd_r : '0;
  assign mean_mm   = mean_r[rda_pkg::MM_W-1:0];
  assign mean_nz   = mean_r != '0;
  assign last_slot = a_idx_r == AW'(ANCHORS - 1);
  assign out_free  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rda_pkg::ST_IDLE: begin
        if (in_valid && in_ok) state_nxt = rda_pkg::ST_ACCUM;
      end
      rda_pkg::ST_ACCUM:     state_nxt = rda_pkg::ST_CHECK;
      rda_pkg::ST_CHECK:     state_nxt = fire ? rda_pkg::ST_SLOT : rda_pkg::ST_IDLE;
      rda_pkg::ST_SLOT: begin
        state_nxt = (cur_cnt == '0) ? rda_pkg::ST_LOAD : rda_pkg::ST_MEAN_GO;
      end
      rda_pkg::ST_MEAN_GO:   state_nxt = rda_pkg::ST_MEAN_WAIT;
      rda_pkg::ST_MEAN_WAIT: begin
        if (div_rsp.done) state_nxt = rda_pkg::ST_RING_RD;
      end
      rda_pkg::ST_RING_RD:   state_nxt = rda_pkg::ST_RING_WR;
      rda_pkg::ST_RING_WR:   state_nxt = rda_pkg::ST_AVG_GO;
      rda_pkg::ST_AVG_GO:    state_nxt = rda_pkg::ST_AVG_WAIT;
      rda_pkg::ST_AVG_WAIT: begin
        if (div_rsp.done) state_nxt = rda_pkg::ST_CM_GO;
      end
      rda_pkg::ST_CM_GO:     state_nxt = rda_pkg::ST_CM_WAIT;
      rda_pkg::ST_CM_WAIT: begin
        if (div_rsp.done) state_nxt = rda_pkg::ST_LOAD;
      end
      rda_pkg::ST_LOAD: begin
        if (out_free) state_nxt = last_slot ? rda_pkg::ST_IDLE : rda_pkg::ST_SLOT;
      end
      default:               state_nxt = rda_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall         = 1'b1;
    accept_c         = 1'b0;
    ring_we_c        = 1'b0;
    load_c           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = cur_sum;
    div_req.divisor  = cur_cnt;
    unique case (state_r)
      rda_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept_c = in_valid;
      end
      rda_pkg::ST_MEAN_GO: begin
        div_req.start = 1'b1;
      end
      rda_pkg::ST_RING_WR: begin
        ring_we_c = mean_nz;
      end
      rda_pkg::ST_AVG_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = rda_pkg::DIV_W'(cur_tot);
        div_req.divisor  = rda_pkg::DVSR_W'(SMOOTH_DEPTH);
      end
      rda_pkg::ST_CM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = rda_pkg::DIV_W'(filt_r);
        div_req.divisor  = rda_pkg::DVSR_W'(rda_pkg::MM_PER_CM);
      end
      rda_pkg::ST_LOAD: begin
        load_c = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // control state, sums, counts, ring bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rda_pkg::ST_IDLE;
      refresh_r   <= rda_pkg::REFRESH_RST;
      ring_vld_r  <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < ANCHORS; k++) begin
        sum_r[k]   <= '0;
        cnt_r[k]   <= '0;
        pos_r[k]   <= '0;
        total_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // register write
      if (cfg_valid) refresh_r <= cfg_data;
      // accumulate the captured report
      if (state_r == rda_pkg::ST_ACCUM) begin
        sum_r[a_idx_r] <= cur_sum + rda_pkg::SUM_W'(addend_r);
        if (cur_cnt != rda_pkg::CNT_MAX) cnt_r[a_idx_r] <= cur_cnt + 1'b1;
      end
      // push a nonzero mean, keep the ring total current
      if (ring_we_c) begin
        ring_vld_r[ring_addr] <= 1'b1;
        total_r[a_idx_r]      <= cur_tot - TOT_W'(old_mm) + TOT_W'(mean_mm);
        pos_r[a_idx_r]        <= next_pos;
      end
      // result handed to the output register, anchor cleared
      if (load_c) begin
        sum_r[a_idx_r] <= '0;
        cnt_r[a_idx_r] <= '0;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (ring_we_c) ring_mem[ring_addr] <= mean_mm;
    if (state_r == rda_pkg::ST_RING_RD) ring_rd_r <= ring_mem[ring_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept_c) begin
      a_idx_r  <= in_data.anchor_number[AW-1:0];
      addend_r <= addend;
    end
    if (state_r == rda_pkg::ST_CHECK) a_idx_r <= '0;
    if (load_c && !last_slot) a_idx_r <= a_idx_r + 1'b1;
    if (state_r == rda_pkg::ST_SLOT) begin
      had_r <= cur_cnt != '0;
      if (cur_cnt == '0) begin
        filt_r <= '0;
        cm_r   <= '0;
      end
    end
    if (state_r == rda_pkg::ST_MEAN_WAIT && div_rsp.done) mean_r <= div_rsp.quotient;
    if (state_r == rda_pkg::ST_RING_RD) old_vld_r <= ring_vld_r[ring_addr];
    if (state_r == rda_pkg::ST_AVG_WAIT && div_rsp.done) begin
      filt_r <= div_rsp.quotient[rda_pkg::MM_W-1:0];
    end
    if (state_r == rda_pkg::ST_CM_WAIT && div_rsp.done) begin
      cm_r <= div_rsp.quotient[rda_pkg::CM_W-1:0];
    end
    if (load_c) begin
      out_data_r.anchor_slot   <= rda_pkg::SLOT_W'(a_idx_r);
      out_data_r.filtered_mm   <= filt_r;
      out_data_r.filtered_cm   <= cm_r;
      out_data_r.had_reports   <= had_r;
      out_data_r.last_of_round <= last_slot;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* rtl/rda_checker.sv */
// rda_checker: port-level assertions for the ranging distance averager
// bound to the top level below; depends on rda_pkg
`default_nettype none

module rda_checker #(
  parameter int ANCHORS = 4
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input rda_pkg::rda_in_t          in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input rda_pkg::rda_out_t         out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an in-range report keeps the block busy on the next cycle
  a_busy_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.anchor_number < rda_pkg::BYTE_W'(ANCHORS))
    |=> in_stall)
    else $error("report not followed by accumulation");

  // anchor without reports gives zero distance
  a_no_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.had_reports
    |-> out_data.filtered_mm == '0 && out_data.filtered_cm == '0)
    else $error("nonzero distance for anchor without reports");

  // slot in range, last flag only on the final slot
  a_slot_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.anchor_slot < rda_pkg::SLOT_W'(ANCHORS)) &&
                  (out_data.last_of_round ==
                   (out_data.anchor_slot == rda_pkg::SLOT_W'(ANCHORS - 1))))
    else $error("bad slot or last flag");

endmodule

bind ranging_distance_averager rda_checker #(.ANCHORS(ANCHORS)) u_rda_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire
